@@ rtl/assert_macros.svh @@
// Assertion macros shared by the edge magnitude RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pem_pkg.sv @@
// Package for the Prewitt edge magnitude block: widths, register codes,
// reset values and the controller/datapath command and status structs.
// No dependencies.
package pem_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 11;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Square root unit: radicand holds gx^2 + gy^2 (below 2^21), two bits per step
    localparam int RAD_W      = 2 * MAG_W;
    localparam int REM_W      = MAG_W + 3;
    localparam int ROOT_STEPS = MAG_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Reset values and defaults
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
    localparam int MAX_WIDTH_DEFAULT     = 2048;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // take the pixel, advance the raster position
        logic mem_read;    // read both line stores at the captured column
        logic win_shift;   // write back line stores, shift the window
        logic grad_load;   // register both gradients
        logic root_start;  // load gx^2 + gy^2 into the root unit
        logic out_load;    // move the result into the output register
    } pem_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic interior;    // captured pixel produces a result
        logic root_busy;   // root unit still iterating
        logic out_free;    // output register can take a new item
    } pem_status_t;

endpackage

@@ rtl/pem_intf.sv @@
// Valid/ready channel interfaces for pixels, results and register writes.
// Depends on pem_pkg.
interface pem_pixel_if
    import pem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface pem_result_if
    import pem_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]         magnitude;
    logic                     last_in_frame;

    modport source (output valid, output grad_x, output grad_y, output magnitude,
                    output last_in_frame, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input magnitude,
                    input last_in_frame, output ready);
endinterface

interface pem_cfg_if
    import pem_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/prewitt_edge_magnitude.sv @@
// Prewitt edge magnitude block: top level joining controller and datapath.
// Depends on pem_pkg, pem_intf, pem_ctrl, pem_datapath.
//
// Grey pixels enter in raster order on the pixels channel; each interior
// pixel yields one item on results with the horizontal gradient (right minus
// left column), the vertical gradient (top minus bottom row), the floor of
// the gradient magnitude and a flag on the last interior result of the frame.
// Border pixels give no item. A pixel on the top two rows or left two columns
// goes through capture, line store read and window shift; an interior pixel
// then loads the gradients, starts the 11-step, two-bits-per-cycle square
// root, waits for it, then waits for the output register to free up. The next
// pixel is taken while a result still sits in the output register. Writes on
// cfg are always taken: index 0 sets frame_width (clamped to 3..MAX_WIDTH),
// index 1 sets frame_height (at least 3); either restarts the frame at row 0,
// column 0. The line stores are not cleared; their stale contents only reach
// border positions. There is no clearing pass after reset.
module prewitt_edge_magnitude
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    pem_pixel_if.sink     pixels,
    pem_result_if.source  results,
    pem_cfg_if.sink       cfg
);

    pem_cmd_t    cmd;
    pem_status_t status;

    pem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pixels.pixel),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .grad_x        (results.grad_x),
        .grad_y        (results.grad_y),
        .magnitude     (results.magnitude),
        .last_in_frame (results.last_in_frame)
    );

endmodule

@@ rtl/pem_isqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
// Depends on pem_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pem_isqrt
    import pem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] value,
    output logic             busy,
    output logic [MAG_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_STEPS + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [RAD_W-1:0] value_reg;
    logic [REM_W-1:0] rem_reg;
    logic [MAG_W-1:0] root_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    // One restoring step
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Radicand, remainder and partial root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg   <= value;
            value_reg <= value;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg, "root unit did not start")
    `ASSERT_IMPL(a_root_floor, clk, rst_n, $fell(busy_reg),
        ((24'(root_reg) * 24'(root_reg)) <= 24'(value_reg)) &&
        (((24'(root_reg) + 24'd1) * (24'(root_reg) + 24'd1)) > 24'(value_reg)),
        "root is not the floor square root")

endmodule

@@ rtl/pem_datapath.sv @@
// Datapath: configuration registers, raster position, line stores, 3x3 window,
// gradients, root unit and output register. Depends on pem_pkg, pem_isqrt, assert_macros.svh.
`include "assert_macros.svh"

module pem_datapath
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // pixel payload
    input  logic [PIX_W-1:0]         pixel,
    // register writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // controller
    input  pem_cmd_t                 cmd,
    output pem_status_t              status,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output logic [MAG_W-1:0]         magnitude,
    output logic                     last_in_frame
);

    localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W   = (WIDTH_W > FW_W) ? WIDTH_W : FW_W;
    localparam int SUM_W   = PIX_W + 2;

    // Configuration and position
    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [COL_W-1:0] col_reg;
    logic [FH_W-1:0]  row_reg;

    // Captured item
    logic [PIX_W-1:0] px_reg;
    logic [COL_W-1:0] colq_reg;
    logic             interior_reg;
    logic             last_reg;
    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] mid_reg;

    // Line stores
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    // Window [row: top, mid, bottom][col: left, mid, right]
    logic [PIX_W-1:0] win_reg [3][3];

    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [GRAD_W-1:0] out_gx_reg;
    logic signed [GRAD_W-1:0] out_gy_reg;
    logic [MAG_W-1:0]         out_mag_reg;
    logic                     out_last_reg;

    logic [CMP_W-1:0] fw_ext;
    logic [CMP_W-1:0] eff_w;
    logic [FH_W-1:0]  eff_h;
    logic             col_last;
    logic             row_last;
    logic             cfg_hit;

    logic [SUM_W-1:0] left_sum;
    logic [SUM_W-1:0] right_sum;
    logic [SUM_W-1:0] upper_sum;
    logic [SUM_W-1:0] lower_sum;

    logic signed [RAD_W-1:0] gx_sq;
    logic signed [RAD_W-1:0] gy_sq;
    logic [RAD_W-1:0]        sq_sum;
    logic                    root_busy;
    logic [MAG_W-1:0]        root;

    // Effective frame size and end-of-row / end-of-frame
    assign fw_ext = CMP_W'(fw_reg);

    always_comb
    begin
        if (fw_ext < CMP_W'(3))
        begin
            eff_w = CMP_W'(3);
        end
        else if (fw_ext > CMP_W'(MAX_WIDTH))
        begin
            eff_w = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
    end

    assign eff_h    = (fh_reg < FH_W'(3)) ? FH_W'(3) : fh_reg;
    assign col_last = (CMP_W'(col_reg) == (eff_w - CMP_W'(1)));
    assign row_last = (row_reg == (eff_h - FH_W'(1)));

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    // Registers and raster position; a write to either register restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FW_RESET;
            fh_reg  <= FH_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                fw_reg <= cfg_data[FW_W-1:0];
            end
            else
            begin
                fh_reg <= cfg_data[FH_W-1:0];
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.capture)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + FH_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg       <= pixel;
            colq_reg     <= col_reg;
            interior_reg <= (row_reg >= FH_W'(2)) && (CMP_W'(col_reg) >= CMP_W'(2));
            last_reg     <= col_last && row_last;
        end
    end

    // Line stores: read, then write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            top_reg <= upper_mem[colq_reg];
            mid_reg <= middle_mem[colq_reg];
        end
        if (cmd.win_shift)
        begin
            upper_mem[colq_reg]  <= mid_reg;
            middle_mem[colq_reg] <= px_reg;
        end
    end

    // Window shift, new column enters on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (cmd.win_shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_reg;
            win_reg[1][2] <= mid_reg;
            win_reg[2][2] <= px_reg;
        end
    end

    // Prewitt column and row sums
    assign left_sum  = SUM_W'(win_reg[0][0]) + SUM_W'(win_reg[1][0]) + SUM_W'(win_reg[2][0]);
    assign right_sum = SUM_W'(win_reg[0][2]) + SUM_W'(win_reg[1][2]) + SUM_W'(win_reg[2][2]);
    assign upper_sum = SUM_W'(win_reg[0][0]) + SUM_W'(win_reg[0][1]) + SUM_W'(win_reg[0][2]);
    assign lower_sum = SUM_W'(win_reg[2][0]) + SUM_W'(win_reg[2][1]) + SUM_W'(win_reg[2][2]);

    always_ff @(posedge clk)
    begin
        if (cmd.grad_load)
        begin
            gx_reg <= $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
            gy_reg <= $signed({1'b0, upper_sum}) - $signed({1'b0, lower_sum});
        end
    end

    // Squares feed the root unit's input registers
    assign gx_sq  = RAD_W'(gx_reg) * RAD_W'(gx_reg);
    assign gy_sq  = RAD_W'(gy_reg) * RAD_W'(gy_reg);
    assign sq_sum = $unsigned(gx_sq) + $unsigned(gy_sq);

    pem_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .value (sq_sum),
        .busy  (root_busy),
        .root  (root)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_gx_reg   <= gx_reg;
            out_gy_reg   <= gy_reg;
            out_mag_reg  <= root;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign grad_x        = out_gx_reg;
    assign grad_y        = out_gy_reg;
    assign magnitude     = out_mag_reg;
    assign last_in_frame = out_last_reg;

    assign status.interior  = interior_reg;
    assign status.root_busy = root_busy;
    assign status.out_free  = !out_valid_reg || out_ready;

    `ASSERT_NEXT(a_frame_wrap, clk, rst_n, cmd.capture && col_last && row_last,
        (col_reg == '0) && (row_reg == '0), "raster position did not wrap at frame end")

endmodule

@@ rtl/pem_ctrl.sv @@
// Controller state machine: sequences capture, line store access, window
// shift, gradients, root and result hand-off. Depends on pem_pkg, assert_macros.svh.
`include "assert_macros.svh"

module pem_ctrl
    import pem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pem_status_t status,
    output pem_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_WIN  = 3'd2;
    localparam logic [2:0] ST_GRAD = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_WIN;
            end
            ST_WIN:
            begin
                cmd.win_shift = 1'b1;
                state_next    = status.interior ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD:
            begin
                cmd.grad_load = 1'b1;
                state_next    = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (!status.root_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    `ASSERT_NEXT(a_accept_reads, clk, rst_n, in_valid && in_ready,
        state_reg == ST_READ, "accepted item not followed by line store read")
    `ASSERT_NEXT(a_border_done, clk, rst_n, (state_reg == ST_WIN) && !status.interior,
        state_reg == ST_IDLE, "border pixel did not return to idle")

endmodule
